// ===== design/sssc_pkg.sv =====
// shared types, codes and glyph tables for the seven-segment scan controller
// no dependencies
`default_nettype none

package sssc_pkg;

    // operation codes carried on s_tuser
    typedef enum logic [2:0] {
        FUNC_TICK   = 3'd0,
        FUNC_TEXT   = 3'd1,
        FUNC_RAW    = 3'd2,
        FUNC_NUMBER = 3'd3,
        FUNC_CLEAR  = 3'd4
    } func_t;

    // register indexes on the apb port (paddr[2])
    localparam logic REG_BRIGHTNESS = 1'b0;
    localparam logic REG_ANODE_MODE = 1'b1;

    localparam int          DUTY_W      = 4;
    localparam logic [4:0]  DUTY_STEPS  = 5'd10;
    localparam logic [3:0]  BRIGHT_MAX  = 4'd10;
    localparam logic [3:0]  BRIGHT_RST  = 4'd10;

    localparam logic [7:0]  GLYPH_BLANK = 8'h00;
    localparam logic [7:0]  GLYPH_MINUS = 8'h40;
    localparam logic [7:0]  POINT_BIT   = 8'h80;

    localparam logic signed [15:0] NUM_MIN = -16'sd999;
    localparam logic signed [15:0] NUM_MAX = 16'sd9999;

    localparam logic [13:0] UNIT_1000 = 14'd1000;
    localparam logic [13:0] UNIT_100  = 14'd100;
    localparam logic [13:0] UNIT_10   = 14'd10;

    typedef logic [7:0] glyph_t;

    localparam glyph_t HEX_GLYPHS [16] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
    };

    typedef struct packed {
        logic [3:0]  digit;
        logic [13:0] rest;
    } split_t;

    // leading decimal digit by parallel compares against multiples of unit
    function automatic split_t digit_split(input logic [13:0] value,
                                           input logic [13:0] unit);
        split_t     res;
        logic [17:0] step;
        res.digit = 4'd0;
        res.rest  = value;
        for (int k = 1; k < 10; k++) begin
            step = 18'(k) * {4'b0000, unit};
            if ({4'b0000, value} >= step) begin
                res.digit = 4'(k);
                res.rest  = value - step[13:0];
            end
        end
        return res;
    endfunction

    // ascii to segment pattern, unsupported characters are blank
    function automatic glyph_t char_glyph(input logic [7:0] c);
        glyph_t g;
        g = GLYPH_BLANK;
        if (c >= 8'h30 && c <= 8'h39) begin
            g = HEX_GLYPHS[4'(c - 8'h30)];
        end else if (c >= 8'h41 && c <= 8'h46) begin
            g = HEX_GLYPHS[4'(c - 8'h41 + 8'd10)];
        end else if (c >= 8'h61 && c <= 8'h66) begin
            g = HEX_GLYPHS[4'(c - 8'h61 + 8'd10)];
        end else begin
            case (c)
                8'h2D:   g = GLYPH_MINUS; // '-'
                8'h5F:   g = 8'h08;       // '_'
                8'h48:   g = 8'h76;       // 'H'
                8'h68:   g = 8'h74;       // 'h'
                8'h4C:   g = 8'h38;       // 'L'
                8'h6E:   g = 8'h54;       // 'n'
                8'h6F:   g = 8'h5C;       // 'o'
                8'h50:   g = 8'h73;       // 'P'
                8'h72:   g = 8'h50;       // 'r'
                8'h75:   g = 8'h1C;       // 'u'
                default: g = GLYPH_BLANK;
            endcase
        end
        return g;
    endfunction

endpackage

`default_nettype wire

// ===== design/seven_segment_scan_controller_core.sv =====
// seven-segment scan controller top level: input stage, display state, result stage
// depends on sssc_pkg
`default_nettype none

// channel   | dir | handshake            | payload
// ----------+-----+----------------------+------------------------------------------
// s_        | in  | s_tvalid / s_tready  | s_tuser func, s_tdata bytes/point/number/pad
// m_        | out | m_tvalid / m_tready  | m_tdata segment_pins, digit_pins
// apb       | in  | psel/penable/pready  | brightness @0x0, anode_mode @0x4
//
// one transfer in, one transfer out per item; an item can enter every cycle while the result side is not stalled
// an item passes the input register, then the state update into the result register
// the number split is done in three compare levels, thousands before the input
// register and hundreds then tens after it
// aresetn is synchronous and active low; the block takes items right after reset
// a stalled result holds while the input register still takes one more item

module seven_segment_scan_controller_core
    import sssc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output      logic        s_tready,
    // [7:0] byte_0, [15:8] byte_1, [23:16] byte_2, [31:24] byte_3,
    // [35:32] point_bits, [51:36] number, [54:52] pad_digits, [55] zero
    input  wire logic [55:0] s_tdata,
    // [2:0] func
    input  wire logic [2:0]  s_tuser,

    output      logic        m_tvalid,
    input  wire logic        m_tready,
    // [7:0] segment_pins, [11:8] digit_pins, [15:12] zero
    output      logic [15:0] m_tdata,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [3:0] brightness_reg;
    logic       anode_mode_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= BRIGHT_RST;
            anode_mode_reg <= 1'b0;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_BRIGHTNESS: begin
                    // values above ten saturate
                    brightness_reg <= (pwdata[3:0] > BRIGHT_MAX) ? BRIGHT_MAX : pwdata[3:0];
                end
                REG_ANODE_MODE: begin
                    anode_mode_reg <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_BRIGHTNESS: prdata = {28'd0, brightness_reg};
            REG_ANODE_MODE: prdata = {31'd0, anode_mode_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // input stage: unpack fields, magnitude, range check, thousands digit
    // ------------------------------------------------------------------
    logic               in_valid_reg;
    logic [2:0]         in_func_reg;
    logic [7:0]         in_byte_reg [4];
    logic [3:0]         in_point_reg;
    logic [2:0]         in_pad_reg;
    logic               in_neg_reg;
    logic               in_oor_reg;
    logic [3:0]         in_thou_reg;
    logic [9:0]         in_rem_reg;

    logic               out_valid_reg;
    logic [7:0]         out_seg_reg;
    logic [3:0]         out_dig_reg;

    logic               s_xfer;
    logic               advance;
    logic               proc;

    logic signed [15:0] s_number;
    logic [15:0]        s_mag;
    split_t             s_thou;

    assign advance  = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    assign s_number = $signed(s_tdata[51:36]);
    assign s_mag    = s_number[15] ? 16'(-s_number) : s_number;
    assign s_thou   = digit_split(s_mag[13:0], UNIT_1000);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_func_reg    <= s_tuser;
            in_byte_reg[0] <= s_tdata[7:0];
            in_byte_reg[1] <= s_tdata[15:8];
            in_byte_reg[2] <= s_tdata[23:16];
            in_byte_reg[3] <= s_tdata[31:24];
            in_point_reg   <= s_tdata[35:32];
            in_pad_reg     <= s_tdata[54:52];
            in_neg_reg     <= s_number[15];
            in_oor_reg     <= (s_number < NUM_MIN) || (s_number > NUM_MAX);
            in_thou_reg    <= s_thou.digit;
            in_rem_reg     <= s_thou.rest[9:0];
        end
    end

    // ------------------------------------------------------------------
    // display state and result stage
    // ------------------------------------------------------------------
    glyph_t             glyph_reg [4];
    glyph_t             glyph_next [4];
    logic [3:0]         point_mask_reg, point_mask_next;
    logic [1:0]         scan_reg, scan_next;
    logic [DUTY_W-1:0]  duty_reg, duty_next;
    logic [7:0]         seg_drive_reg, seg_drive_next;
    logic [3:0]         dig_drive_reg, dig_drive_next;

    logic [4:0]         duty_sum;
    logic               lit;
    split_t             hund_split;
    split_t             tens_split;
    logic               ge10, ge100, ge1000;
    glyph_t             num_glyph [4];

    // number text: hundreds and tens from the remainder below one thousand
    always_comb begin
        hund_split = digit_split({4'd0, in_rem_reg}, UNIT_100);
        tens_split = digit_split(hund_split.rest, UNIT_10);
        ge1000     = (in_thou_reg != 4'd0);
        ge100      = ge1000 || (hund_split.digit != 4'd0);
        ge10       = ge100 || (tens_split.digit != 4'd0);

        num_glyph[3] = HEX_GLYPHS[tens_split.rest[3:0]];
        num_glyph[2] = ge10 ? HEX_GLYPHS[tens_split.digit]
                            : ((in_pad_reg >= 3'd2) ? HEX_GLYPHS[0] : GLYPH_BLANK);
        num_glyph[1] = ge100 ? HEX_GLYPHS[hund_split.digit]
                             : ((in_pad_reg >= 3'd3) ? HEX_GLYPHS[0] : GLYPH_BLANK);
        if (in_neg_reg) begin
            num_glyph[0] = GLYPH_MINUS;
        end else begin
            num_glyph[0] = ge1000 ? HEX_GLYPHS[in_thou_reg]
                                  : ((in_pad_reg >= 3'd4) ? HEX_GLYPHS[0] : GLYPH_BLANK);
        end
        if (in_oor_reg) begin
            for (int i = 0; i < 4; i++) begin
                num_glyph[i] = GLYPH_MINUS;
            end
        end
    end

    always_comb begin
        glyph_next      = glyph_reg;
        point_mask_next = point_mask_reg;
        scan_next       = scan_reg;
        duty_next       = duty_reg;
        seg_drive_next  = seg_drive_reg;
        dig_drive_next  = dig_drive_reg;

        duty_sum = {1'b0, duty_reg} + 5'd1;
        lit      = 1'b0;

        case (in_func_reg)
            FUNC_TICK: begin
                duty_next      = (duty_sum >= DUTY_STEPS) ? '0 : duty_sum[DUTY_W-1:0];
                scan_next      = scan_reg + 2'd1;
                lit            = brightness_reg > duty_next;
                dig_drive_next = 4'd0;
                // dark tick keeps the last segment levels
                if (lit) begin
                    seg_drive_next = glyph_reg[scan_next]
                                   | (point_mask_reg[scan_next] ? POINT_BIT : 8'h00);
                    dig_drive_next = 4'b0001 << scan_next;
                end
            end
            FUNC_TEXT: begin
                for (int i = 0; i < 4; i++) begin
                    glyph_next[i] = char_glyph(in_byte_reg[i]);
                end
                point_mask_next = in_point_reg;
            end
            FUNC_RAW: begin
                // point mask is kept on a raw load
                for (int i = 0; i < 4; i++) begin
                    glyph_next[i] = in_byte_reg[i];
                end
            end
            FUNC_NUMBER: begin
                glyph_next      = num_glyph;
                point_mask_next = in_oor_reg ? 4'd0 : in_point_reg;
            end
            FUNC_CLEAR: begin
                for (int i = 0; i < 4; i++) begin
                    glyph_next[i] = GLYPH_BLANK;
                end
                point_mask_next = 4'd0;
                seg_drive_next  = 8'd0;
                dig_drive_next  = 4'd0;
            end
            default: begin
                // unused codes leave the state alone and report the pins
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                glyph_reg[i] <= GLYPH_BLANK;
            end
            point_mask_reg <= 4'd0;
            scan_reg       <= 2'd0;
            duty_reg       <= '0;
            seg_drive_reg  <= 8'd0;
            dig_drive_reg  <= 4'd0;
        end else if (proc) begin
            glyph_reg      <= glyph_next;
            point_mask_reg <= point_mask_next;
            scan_reg       <= scan_next;
            duty_reg       <= duty_next;
            seg_drive_reg  <= seg_drive_next;
            dig_drive_reg  <= dig_drive_next;
        end
    end

    // result register: physical pin levels after polarity
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            out_seg_reg <= anode_mode_reg ? ~seg_drive_next : seg_drive_next;
            out_dig_reg <= anode_mode_reg ? dig_drive_next : ~dig_drive_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_dig_reg, out_seg_reg};

`ifndef SYNTHESIS
    // at most one digit is ever enabled
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(dig_drive_reg))
        else $error("more than one digit enabled");

    // duty counter stays inside its cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, duty_reg} < DUTY_STEPS)
        else $error("duty counter out of range");

    // zero brightness keeps every digit dark after a tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && in_func_reg == FUNC_TICK && brightness_reg == 4'd0)
        |=> (dig_drive_reg == 4'd0))
        else $error("digit lit at zero brightness");

    // input side only stalls when both stages hold an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire

// ===== dv/sssc_pin_checker.sv =====
`timescale 1ns / 100ps
// pin-level checker for the seven-segment scan controller: mirrors apb register
// writes, predicts the pin levels for every input transfer and compares them with
// the result transfers; depends on sssc_pkg for the operation and register codes
module sssc_pin_checker
    import sssc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [55:0] s_tdata,
    input  wire logic [2:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               fail_count,
    output int               due_count
);

    typedef struct packed {
        logic [7:0] segs;
        logic [3:0] digits;
    } pins_t;

    localparam int         DUTY_WRAP   = 10;
    localparam logic [3:0] BRIGHT_CAP  = 4'd10;
    localparam logic [3:0] BRIGHT_INIT = 4'd10;
    localparam logic [7:0] DOT_SEG     = 8'h80;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam int         SHOW_MIN    = -999;
    localparam int         SHOW_MAX    = 9999;

    logic [7:0] glyphs [4];
    logic [3:0] dots;
    logic [1:0] scan;
    logic [3:0] duty;
    logic [7:0] seg_drive;
    logic [3:0] dig_drive;
    logic [3:0] bright;
    logic       anode;
    pins_t      pins_due [$];

    function automatic logic [7:0] ascii_segments(input logic [7:0] c);
        case (c)
            "0":      return 8'h3F;
            "1":      return 8'h06;
            "2":      return 8'h5B;
            "3":      return 8'h4F;
            "4":      return 8'h66;
            "5":      return 8'h6D;
            "6":      return 8'h7D;
            "7":      return 8'h07;
            "8":      return 8'h7F;
            "9":      return 8'h6F;
            "A", "a": return 8'h77;
            "B", "b": return 8'h7C;
            "C", "c": return 8'h39;
            "D", "d": return 8'h5E;
            "E", "e": return 8'h79;
            "F", "f": return 8'h71;
            "-":      return 8'h40;
            "_":      return 8'h08;
            "H":      return 8'h76;
            "h":      return 8'h74;
            "L":      return 8'h38;
            "n":      return 8'h54;
            "o":      return 8'h5C;
            "P":      return 8'h73;
            "r":      return 8'h50;
            "u":      return 8'h1C;
            default:  return 8'h00;
        endcase
    endfunction

    function automatic void load_chars(input logic [7:0] c0, input logic [7:0] c1,
                                       input logic [7:0] c2, input logic [7:0] c3,
                                       input logic [3:0] pts);
        glyphs[0] = ascii_segments(c0);
        glyphs[1] = ascii_segments(c1);
        glyphs[2] = ascii_segments(c2);
        glyphs[3] = ascii_segments(c3);
        dots      = pts;
    endfunction

    // decimal formatting with leading blanks or zeros, minus sign at the far left
    function automatic void show_value(input logic signed [15:0] n,
                                       input logic [2:0] pad_req, input logic [3:0] pts);
        int         v;
        int         pad;
        logic [7:0] ch [4];
        bit         neg;
        v   = int'(n);
        pad = (pad_req > 3'd4) ? 4 : int'(pad_req);
        if (v < SHOW_MIN || v > SHOW_MAX) begin
            load_chars("-", "-", "-", "-", 4'h0);
            return;
        end
        ch  = '{" ", " ", " ", " "};
        neg = (v < 0);
        if (neg) begin
            ch[0] = "-";
            v = -v;
        end
        ch[3] = 8'(ASCII_ZERO + v % 10);
        v = v / 10;
        ch[2] = (v != 0) ? 8'(ASCII_ZERO + v % 10) : ((pad >= 2) ? "0" : " ");
        v = v / 10;
        ch[1] = (v != 0) ? 8'(ASCII_ZERO + v % 10) : ((pad >= 3) ? "0" : " ");
        v = v / 10;
        if (!neg) begin
            ch[0] = (v != 0) ? 8'(ASCII_ZERO + v % 10) : ((pad >= 4) ? "0" : " ");
        end
        load_chars(ch[0], ch[1], ch[2], ch[3], pts);
    endfunction

    // applies one item to the display state and returns the pin levels it leaves
    function automatic pins_t advance_display(input logic [2:0] func, input logic [55:0] d);
        case (func)
            FUNC_TICK: begin
                duty      = (duty >= 4'(DUTY_WRAP - 1)) ? 4'd0 : duty + 4'd1;
                dig_drive = 4'h0;
                scan      = scan + 2'd1;
                if (bright > duty) begin
                    seg_drive = glyphs[scan] | (dots[scan] ? DOT_SEG : 8'h00);
                    dig_drive = 4'b0001 << scan;
                end
            end
            FUNC_TEXT:   load_chars(d[7:0], d[15:8], d[23:16], d[31:24], d[35:32]);
            FUNC_RAW:    glyphs = '{d[7:0], d[15:8], d[23:16], d[31:24]};
            FUNC_NUMBER: show_value(d[51:36], d[54:52], d[35:32]);
            FUNC_CLEAR: begin
                dig_drive = 4'h0;
                seg_drive = 8'h00;
                glyphs    = '{8'h00, 8'h00, 8'h00, 8'h00};
                dots      = 4'h0;
            end
            default: ;
        endcase
        if (anode) begin
            return pins_t'{segs: ~seg_drive, digits: dig_drive};
        end
        return pins_t'{segs: seg_drive, digits: ~dig_drive};
    endfunction

    always @(posedge aclk) begin : watch
        pins_t want;
        pins_t got;
        if (!aresetn) begin
            glyphs    = '{8'h00, 8'h00, 8'h00, 8'h00};
            dots      = 4'h0;
            scan      = 2'd0;
            duty      = 4'd0;
            seg_drive = 8'h00;
            dig_drive = 4'h0;
            bright    = BRIGHT_INIT;
            anode     = 1'b0;
            pins_due.delete();
        end else begin
            // a result leaves only after its item has passed the input and result registers, so compare first
            if (m_tvalid && m_tready) begin
                got = pins_t'{segs: m_tdata[7:0], digits: m_tdata[11:8]};
                if (pins_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: result transfer with nothing outstanding: segments %h digits %h",
                             $time, got.segs, got.digits);
                end else begin
                    want = pins_due.pop_front();
                    if (got.segs !== want.segs) begin
                        fail_count++;
                        $display("%0t: segment_pins expected %h got %h",
                                 $time, want.segs, got.segs);
                    end
                    if (got.digits !== want.digits) begin
                        fail_count++;
                        $display("%0t: digit_pins expected %h got %h",
                                 $time, want.digits, got.digits);
                    end
                    if (m_tdata[15:12] !== 4'h0) begin
                        fail_count++;
                        $display("%0t: result fill bits expected 0 got %h",
                                 $time, m_tdata[15:12]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                pins_due.push_back(advance_display(s_tuser, s_tdata));
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_BRIGHTNESS) begin
                    bright = (pwdata[3:0] > BRIGHT_CAP) ? BRIGHT_CAP : pwdata[3:0];
                end else begin
                    anode = pwdata[0];
                end
            end
        end
        due_count = pins_due.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// testbench top for the seven-segment scan controller: clock, reset, register
// writes, item traffic, result-side backpressure and the verdict
// depends on sssc_pkg, sssc_pin_checker and seven_segment_scan_controller_core
module tb_top
    import sssc_pkg::*;
();

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 9;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int PHASES          = 7;
    localparam int HOLD_CYCLES     = 120;   // long result-side hold-off
    localparam int IDLE_LIMIT      = 2000;  // cycles without any transfer
    localparam int DRAIN_CYCLES    = 8;

    // codes the block does not decode, they must leave the state alone
    localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

    localparam logic [2:0] ADDR_BRIGHTNESS = {REG_BRIGHTNESS, 2'b00};
    localparam logic [2:0] ADDR_ANODE_MODE = {REG_ANODE_MODE, 2'b00};

    // register settings per phase: saturation at both ends, dark, dim and full,
    // with junk in the unused upper bits now and then
    localparam logic [31:0] BRIGHT_WRITES [PHASES] = '{
        32'h0000_000F, 32'h0000_0000, 32'h0000_0001, 32'hABCD_0005,
        32'h0000_000A, 32'h0000_0007, 32'h0000_000B
    };
    localparam logic [31:0] ANODE_WRITES [PHASES] = '{
        32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
        32'h0000_0001, 32'hFFFF_FFFE, 32'h0000_0000
    };

    // edges of the number range plus the extremes of the 16-bit field
    localparam logic [15:0] EDGE_VALUES [8] = '{
        16'hFC18, 16'hFC19, 16'd9999, 16'd10000, 16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [55:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = FUNC_TICK;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;

    wire         s_tready;
    wire         m_tvalid;
    wire  [15:0] m_tdata;
    wire  [31:0] prdata;
    wire         pready;

    int          fail_count;
    int          due_count;

    // idling controls for the sender and the receiver processes, and the watchdog's idle count
    bit          tx_gaps       = 1'b1;
    bit          rx_stalls     = 1'b1;
    bit          hold_off_req  = 1'b0;
    int          idle_cycles   = 0;

    // characters the glyph table knows, plus a blank and one it does not
    string       char_pool = "0123456789ABCDEFabcdef-_HhLnoPru G";

    always #(CLK_HALF) aclk = ~aclk;

    seven_segment_scan_controller_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    sssc_pin_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .due_count  (due_count)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // watchdog: any transfer on either channel restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side: ready by default, random stalls, and the one long hold-off
    // that lets the block fill up while the sender keeps offering items
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (rx_stalls && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat (gap_len()) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // one input transfer; chars holds byte_0 in its lowest byte
    task automatic offer_item(input logic [2:0] func, input logic [31:0] chars,
                              input logic [3:0] pts, input logic [15:0] value,
                              input logic [2:0] pad);
        s_tuser  <= func;
        s_tdata  <= {1'b0, pad, value, pts, chars};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // valid stays high into the next item unless a gap is taken here
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat (gap_len()) @(posedge aclk);
        end
    endtask

    task automatic offer_random_item();
        logic [2:0]  func;
        logic [31:0] chars;
        logic [15:0] value;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            func = FUNC_TICK;
        end else if (pick < 62) begin
            func = FUNC_TEXT;
        end else if (pick < 72) begin
            func = FUNC_RAW;
        end else if (pick < 94) begin
            func = FUNC_NUMBER;
        end else if (pick < 97) begin
            func = FUNC_CLEAR;
        end else begin
            func = 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
        end
        chars = $urandom();
        // text mostly from known characters, the rest any byte at all
        if (func == FUNC_TEXT && $urandom_range(0, 3) != 0) begin
            for (int k = 0; k < 4; k++) begin
                chars[8*k +: 8] = char_pool[$urandom_range(0, char_pool.len() - 1)];
            end
        end
        value = $urandom();
        case ($urandom_range(0, 5))
            0: value = 16'($urandom_range(0, 240)) - 16'd120;  // near zero, padding shows
            1: value = 16'($urandom_range(0, 9999));
            2: value = 16'($urandom_range(0, 998)) - 16'd999;  // negative in range
            3: value = EDGE_VALUES[$urandom_range(0, 7)];
            default: ;                                          // whole field
        endcase
        offer_item(func, chars, 4'($urandom()), value, 3'($urandom()));
    endtask

    // stop offering and wait until every outstanding result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (due_count != 0) @(posedge aclk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part, reset settings; byte_3 comes first in each concatenation
        offer_item(FUNC_TICK, 32'h0, 4'h0, 16'h0, 3'd0);              // blank glyph lit
        offer_item(FUNC_TEXT, {"f", "A", "9", "0"}, 4'hF, 16'h0, 3'd0);
        offer_item(FUNC_TICK, 32'h0, 4'h0, 16'h0, 3'd0);
        offer_item(FUNC_TEXT, {"P", "o", "n", "L"}, 4'h0, 16'h0, 3'd0);
        offer_item(FUNC_TEXT, {"_", "-", "u", "r"}, 4'h5, 16'h0, 3'd0);
        offer_item(FUNC_TEXT, {"a", "F", "h", "H"}, 4'hA, 16'h0, 3'd0);
        // unsupported characters, including the byte extremes, come out blank
        offer_item(FUNC_TEXT, {" ", "G", 8'hFF, 8'h00}, 4'hF, 16'h0, 3'd0);
        offer_item(FUNC_TICK, 32'h0, 4'h0, 16'h0, 3'd0);
        // raw load keeps the point mask, its point field is ignored
        offer_item(FUNC_RAW, 32'h55AA_00FF, 4'h3, 16'h0, 3'd0);
        offer_item(FUNC_TICK, 32'h0, 4'h0, 16'h0, 3'd0);
        // out of range numbers show dashes and drop the points
        offer_item(FUNC_NUMBER, 32'h0, 4'hF, 16'h8000, 3'd0);
        offer_item(FUNC_NUMBER, 32'h0, 4'hF, 16'h7FFF, 3'd7);
        offer_item(FUNC_NUMBER, 32'h0, 4'h1, 16'd10000, 3'd4);
        offer_item(FUNC_NUMBER, 32'h0, 4'h2, 16'hFC18, 3'd0);          // minus 1000
        // range limits and padding, negative padding mirrors the positive case
        offer_item(FUNC_NUMBER, 32'h0, 4'h1, 16'hFC19, 3'd4);          // minus 999
        offer_item(FUNC_NUMBER, 32'h0, 4'h8, 16'd9999, 3'd0);
        offer_item(FUNC_NUMBER, 32'h0, 4'h0, 16'd0, 3'd0);
        offer_item(FUNC_NUMBER, 32'h0, 4'h0, 16'd0, 3'd4);
        offer_item(FUNC_NUMBER, 32'h0, 4'h4, 16'hFFFB, 3'd2);          // minus 5
        offer_item(FUNC_NUMBER, 32'h0, 4'h4, 16'hFFFB, 3'd3);
        offer_item(FUNC_NUMBER, 32'h0, 4'h6, 16'd7, 3'd7);             // pad over four
        offer_item(FUNC_NUMBER, 32'h0, 4'h0, 16'hFFD3, 3'd1);          // minus 45
        offer_item(FUNC_TICK, 32'h0, 4'h0, 16'h0, 3'd0);
        offer_item(FUNC_CLEAR, 32'hFFFF_FFFF, 4'hF, 16'hFFFF, 3'd7);
        for (int f = FUNC_SPARE_FIRST; f <= FUNC_SPARE_LAST; f++) begin
            offer_item(3'(f), $urandom(), 4'($urandom()), 16'($urandom()), 3'($urandom()));
        end

        // random part, one register setting per phase; phase 0 carries the long
        // hold-off with a gap-free sender, phase 3 runs with no idling at all
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            write_reg(ADDR_BRIGHTNESS, BRIGHT_WRITES[p]);
            write_reg(ADDR_ANODE_MODE, ANODE_WRITES[p]);
            tx_gaps   = (p != 0 && p != 3);
            rx_stalls = (p != 3);
            if (p == 0) begin
                hold_off_req = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) offer_random_item();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/sssc_pkg.sv
design/seven_segment_scan_controller_core.sv
dv/sssc_pin_checker.sv
dv/tb_top.sv
